// ----- rtl/etr_pkg.sv -----
// Package for the throttle gear ramp: gear and command codes, register
// indexes, step constants, config bank type and saturating helpers.
// No dependencies.
package etr_pkg;

    localparam int W_WIDTH = 12;
    localparam int W_HOLD  = 8;
    localparam int CFG_NUM = 8;
    localparam int W_ADDR  = 3;

    // Ramp steps in microseconds per command
    localparam logic [W_WIDTH-1:0] FWD_STEP      = 12'd10;
    localparam logic [W_WIDTH-1:0] REV_STEP      = 12'd10;
    localparam logic [W_WIDTH-1:0] FWD_STOP_STEP = 12'd20;
    localparam logic [W_WIDTH-1:0] REV_STOP_STEP = 12'd20;
    // Commands spent at the brake width before reverse engages
    localparam logic [W_HOLD-1:0]  HOLD_LIMIT    = 8'd10;

    localparam logic [W_WIDTH-1:0] WIDTH_MAX     = 12'hFFF;

    typedef enum logic [1:0] {
        G_FWD = 2'd0,
        G_PRE = 2'd1,
        G_REV = 2'd2,
        G_NEU = 2'd3
    } t_gear;

    typedef enum logic [1:0] {
        ACT_FWD  = 2'd0,
        ACT_REV  = 2'd1,
        ACT_STOP = 2'd2,
        ACT_HARD = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        LVL_NONE   = 2'd0,
        LVL_CREEP  = 2'd1,
        LVL_CRUISE = 2'd2,
        LVL_FAST   = 2'd3
    } t_level;

    typedef enum logic [W_ADDR-1:0] {
        REG_NEUTRAL    = 3'd0,
        REG_FWD_CREEP  = 3'd1,
        REG_FWD_CRUISE = 3'd2,
        REG_FWD_FAST   = 3'd3,
        REG_REV_CREEP  = 3'd4,
        REG_REV_CRUISE = 3'd5,
        REG_REV_FAST   = 3'd6,
        REG_BRAKE      = 3'd7
    } t_reg_idx;

    typedef logic [CFG_NUM-1:0][W_WIDTH-1:0] t_cfg_bank;

    // Highest index first
    localparam t_cfg_bank CFG_RESET = {
        12'd1300, 12'd1000, 12'd1300, 12'd1400,
        12'd2000, 12'd1700, 12'd1600, 12'd1500
    };

    localparam logic [W_WIDTH-1:0] WIDTH_RESET = 12'd1500;

    typedef struct packed {
        logic [W_WIDTH-1:0] width;
        t_gear              gear;
        logic [W_HOLD-1:0]  hold;
    } t_state;

    function automatic logic [W_WIDTH-1:0] sat_sub(input logic [W_WIDTH-1:0] a,
                                                   input logic [W_WIDTH-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [W_WIDTH-1:0] sat_add(input logic [W_WIDTH-1:0] a,
                                                   input logic [W_WIDTH-1:0] b);
        logic [W_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[W_WIDTH] ? WIDTH_MAX : s[W_WIDTH-1:0];
    endfunction

endpackage

// ----- rtl/etr_cfg.sv -----
// Config register bank for the throttle gear ramp: eight 12-bit widths.
// Depends on etr_pkg.
module etr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [etr_pkg::W_ADDR-1:0]    i_addr,
    input  logic [etr_pkg::W_WIDTH-1:0]   i_wdata,
    output etr_pkg::t_cfg_bank            o_cfg
);

    etr_pkg::t_cfg_bank r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= etr_pkg::CFG_RESET;
        end else if (i_we) begin
            r_cfg[i_addr] <= i_wdata;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/etr_step.sv -----
// Next-state logic of the throttle gear ramp: one command against the
// current width, gear and hold count. Depends on etr_pkg.
module etr_step (
    input  etr_pkg::t_action    i_action,
    input  etr_pkg::t_level     i_level,
    input  etr_pkg::t_state     i_state,
    input  etr_pkg::t_cfg_bank  i_cfg,
    output etr_pkg::t_state     o_state
);

    logic [etr_pkg::W_WIDTH-1:0] neu;
    logic [etr_pkg::W_WIDTH-1:0] brake;
    logic [etr_pkg::W_WIDTH-1:0] fwd_tgt;
    logic [etr_pkg::W_WIDTH-1:0] rev_tgt;
    logic [etr_pkg::W_WIDTH:0]   fwd_sum;
    etr_pkg::t_state             stop_st;
    etr_pkg::t_state             fwd_st;
    etr_pkg::t_state             rev_st;

    assign neu   = i_cfg[etr_pkg::REG_NEUTRAL];
    assign brake = i_cfg[etr_pkg::REG_BRAKE];

    always_comb begin
        case (i_level)
            etr_pkg::LVL_CREEP: begin
                fwd_tgt = i_cfg[etr_pkg::REG_FWD_CREEP];
                rev_tgt = i_cfg[etr_pkg::REG_REV_CREEP];
            end
            etr_pkg::LVL_CRUISE: begin
                fwd_tgt = i_cfg[etr_pkg::REG_FWD_CRUISE];
                rev_tgt = i_cfg[etr_pkg::REG_REV_CRUISE];
            end
            etr_pkg::LVL_FAST: begin
                fwd_tgt = i_cfg[etr_pkg::REG_FWD_FAST];
                rev_tgt = i_cfg[etr_pkg::REG_REV_FAST];
            end
            default: begin
                // no level: forward never uses it, reverse heads to neutral
                fwd_tgt = neu;
                rev_tgt = neu;
            end
        endcase
    end

    // Stop: ramp toward neutral, drop to neutral gear once crossed; pre-reverse gear holds
    always_comb begin
        stop_st = i_state;
        case (i_state.gear)
            etr_pkg::G_NEU: begin
                stop_st.width = neu;
            end
            etr_pkg::G_FWD: begin
                if (i_state.width > neu) begin
                    stop_st.width = etr_pkg::sat_sub(i_state.width, etr_pkg::FWD_STOP_STEP);
                end else begin
                    stop_st.width = neu;
                    stop_st.gear  = etr_pkg::G_NEU;
                end
            end
            etr_pkg::G_REV: begin
                if (i_state.width < neu) begin
                    stop_st.width = etr_pkg::sat_add(i_state.width, etr_pkg::REV_STOP_STEP);
                end else begin
                    stop_st.width = neu;
                    stop_st.gear  = etr_pkg::G_NEU;
                end
            end
            default: begin
                stop_st = i_state;
            end
        endcase
    end

    // Forward: from forward or neutral gear, step up and clamp at the target (no level: stop); other gears hold
    assign fwd_sum = {1'b0, i_state.width} + {1'b0, etr_pkg::FWD_STEP};

    always_comb begin
        fwd_st = i_state;
        if (i_state.gear == etr_pkg::G_FWD || i_state.gear == etr_pkg::G_NEU) begin
            if (i_level == etr_pkg::LVL_NONE) begin
                fwd_st = stop_st;
            end else begin
                if (i_state.width < fwd_tgt && fwd_sum <= {1'b0, fwd_tgt}) begin
                    fwd_st.width = fwd_sum[etr_pkg::W_WIDTH-1:0];
                end else begin
                    fwd_st.width = fwd_tgt;
                end
                fwd_st.gear = etr_pkg::G_FWD;
            end
        end
    end

    // Reverse: brake, hold, then ramp down without clamping on the way
    always_comb begin
        rev_st = i_state;
        case (i_state.gear)
            etr_pkg::G_REV: begin
                if (i_state.width > rev_tgt) begin
                    rev_st.width = etr_pkg::sat_sub(i_state.width, etr_pkg::REV_STEP);
                end else begin
                    rev_st.width = rev_tgt;
                end
            end
            etr_pkg::G_FWD: begin
                rev_st = stop_st;
            end
            etr_pkg::G_NEU: begin
                rev_st.gear  = etr_pkg::G_PRE;
                rev_st.width = etr_pkg::sat_sub(i_state.width, etr_pkg::REV_STEP);
            end
            default: begin
                if (i_state.width > brake) begin
                    rev_st.width = etr_pkg::sat_sub(i_state.width, etr_pkg::REV_STEP);
                    rev_st.hold  = '0;
                end else if (i_state.hold < etr_pkg::HOLD_LIMIT) begin
                    rev_st.width = brake;
                    rev_st.hold  = i_state.hold + 1'b1;
                end else begin
                    rev_st.gear  = etr_pkg::G_REV;
                    rev_st.width = neu;
                    rev_st.hold  = '0;
                end
            end
        endcase
    end

    always_comb begin
        case (i_action)
            etr_pkg::ACT_FWD:  o_state = fwd_st;
            etr_pkg::ACT_REV:  o_state = rev_st;
            etr_pkg::ACT_STOP: o_state = stop_st;
            default: begin
                o_state       = i_state;
                o_state.width = neu;
            end
        endcase
    end

endmodule

// ----- rtl/esc_throttle_gear_ramp.sv -----
// Throttle gear ramp top level. A command accepted at the input first loads the input
// register; when it advances, its result loads the state register, which also serves
// as the result register driving the output.
// Throughput: one command per cycle; the output stage stalls only on m_axis_tready.
// Reset (synchronous, active low): width 1500, neutral gear, hold count zero,
// config registers at their defaults, both stages empty.
module esc_throttle_gear_ramp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [1:0] action, [3:2] speed_level
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [23:0]                  m_axis_tdata,   // [11:0] pulse_us,
                                                         // [21:12] compare_value,
                                                         // [23:22] gear_now
    input  logic                         i_cfg_we,
    input  logic [etr_pkg::W_ADDR-1:0]   i_cfg_addr,
    input  logic [etr_pkg::W_WIDTH-1:0]  i_cfg_wdata
);

    logic               r_in_valid;
    etr_pkg::t_action   r_action;
    etr_pkg::t_level    r_level;
    logic               r_out_valid;
    etr_pkg::t_state    r_state;
    etr_pkg::t_state    n_state;
    etr_pkg::t_cfg_bank cfg;
    logic               advance;

    etr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    etr_step u_step (
        .i_action (r_action),
        .i_level  (r_level),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action <= etr_pkg::t_action'(s_axis_tdata[1:0]);
            r_level  <= etr_pkg::t_level'(s_axis_tdata[3:2]);
        end
    end

    // State doubles as the result register: both change only on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_state.width <= etr_pkg::WIDTH_RESET;
            r_state.gear  <= etr_pkg::G_NEU;
            r_state.hold  <= '0;
        end else begin
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_state.gear, r_state.width[etr_pkg::W_WIDTH-1:2], r_state.width};

endmodule

// ----- rtl/etr_checker.sv -----
// Port-level checks for esc_throttle_gear_ramp, bound to the top level.
// Depends on etr_pkg.
module etr_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tready,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [23:0]                  m_axis_tdata,
    input  logic                         i_cfg_we,
    input  logic [etr_pkg::W_ADDR-1:0]   i_cfg_addr,
    input  logic [etr_pkg::W_WIDTH-1:0]  i_cfg_wdata
);

    // Shadow of the neutral width register
    logic [etr_pkg::W_WIDTH-1:0] r_neu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neu <= etr_pkg::CFG_RESET[etr_pkg::REG_NEUTRAL];
        end else if (i_cfg_we && i_cfg_addr == etr_pkg::REG_NEUTRAL) begin
            r_neu <= i_cfg_wdata;
        end
    end

    // Compare value is always the width divided by four
    a_cmp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[21:12] == m_axis_tdata[11:2])
        else $error("compare value does not match pulse width");

    // Neutral gear is only ever shown at the neutral width
    a_neutral_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[23:22] == etr_pkg::G_NEU) |->
            m_axis_tdata[11:0] == r_neu)
        else $error("neutral gear with a width other than neutral");

    // Input side only backs up when a result is waiting
    a_ready_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind esc_throttle_gear_ramp etr_checker u_etr_checker (.*);
